/* src/string_to_integer_any_base_defines.svh */
// Assertion macros shared by the string-to-integer parser RTL.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef STRING_TO_INTEGER_ANY_BASE_DEFINES_SVH
`define STRING_TO_INTEGER_ANY_BASE_DEFINES_SVH

// Check a property on every clock, quiet while in reset.
`define S2I_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define S2I_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define S2I_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/s2i_pkg.sv */
// Types, character codes and helpers for the string-to-integer parser.
// No dependencies; imported by every module of the block.
package s2i_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned AlphaSym = 16;
  localparam int unsigned LenW     = 5;

  localparam logic [CfgIdxW-1:0] CFG_ALPHA_LO = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ALPHA_HI = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_BASE_LEN = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  typedef enum logic [3:0] {
    PH_SPACE  = 4'b0001,
    PH_SIGN   = 4'b0010,
    PH_DIGIT  = 4'b0100,
    PH_FROZEN = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } in_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               base_invalid;
  } out_t;

  typedef struct packed {
    logic [AlphaSym-1:0][7:0] symbols;
    logic [LenW-1:0]          base_length;
    logic                     base_valid;
  } alpha_t;

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
           (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
  endfunction

endpackage

/* src/s2i_cfg.sv */
// Alphabet and radix registers with alphabet validation.
// Depends on s2i_pkg.
module s2i_cfg #(
  parameter int unsigned MAX_SYMBOLS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [s2i_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [s2i_pkg::CfgDataW-1:0]    cfg_data_i,
  output s2i_pkg::alpha_t                 alpha_o
);
  import s2i_pkg::*;

  localparam logic [LenW-1:0] MaxLen = LenW'(MAX_SYMBOLS);

  logic [CfgDataW-1:0]      alpha_lo_q;
  logic [CfgDataW-1:0]      alpha_hi_q;
  logic [LenW-1:0]          base_len_q;
  logic [AlphaSym-1:0][7:0] sym;
  logic                     bad;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_lo_q <= '0;
      alpha_hi_q <= '0;
      base_len_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ALPHA_LO: alpha_lo_q <= cfg_data_i;
        CFG_ALPHA_HI: alpha_hi_q <= cfg_data_i;
        CFG_BASE_LEN: base_len_q <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  assign sym = {alpha_hi_q, alpha_lo_q};

  always_comb begin
    bad = (base_len_q < LenW'(2)) || (base_len_q > MaxLen);
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      if (LenW'(i) < base_len_q) begin
        if ((sym[i] == CH_NUL) || (sym[i] == CH_PLUS) || (sym[i] == CH_MINUS) ||
            is_space(sym[i])) begin
          bad = 1'b1;
        end
        for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
          if ((LenW'(j) < base_len_q) && (sym[j] == sym[i])) begin
            bad = 1'b1;
          end
        end
      end
    end
  end

  assign alpha_o.symbols     = sym;
  assign alpha_o.base_length = base_len_q;
  assign alpha_o.base_valid  = !bad;

endmodule

/* src/s2i_parse.sv */
// Per-character parse state: whitespace skip, sign run, digit accumulation.
// Depends on s2i_pkg and the assertion macro header.
module s2i_parse #(
  parameter int unsigned MAX_SYMBOLS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_en_i,
  input  s2i_pkg::in_t    item_i,
  input  s2i_pkg::alpha_t alpha_i,
  output s2i_pkg::out_t   res_o
);
  import s2i_pkg::*;
  `include "string_to_integer_any_base_defines.svh"

  localparam int unsigned SymW   = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam logic [LenW-1:0] MaxLen = LenW'(MAX_SYMBOLS);

  phase_e      phase_q, phase_d;
  logic        neg_q, neg_d;
  logic [31:0] acc_q, acc_d;

  logic [LenW-1:0] n_used;
  logic            hit_any;
  logic [SymW-1:0] digit;
  logic [7:0]      c;

  assign c      = item_i.char_code;
  assign n_used = (alpha_i.base_length > MaxLen) ? MaxLen : alpha_i.base_length;

  always_comb begin
    hit_any = 1'b0;
    digit   = '0;
    for (int k = MAX_SYMBOLS - 1; k >= 0; k--) begin
      if ((LenW'(k) < n_used) && (alpha_i.symbols[k] == c) && (c != CH_NUL)) begin
        hit_any = 1'b1;
        digit   = SymW'(k);
      end
    end
  end

  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    acc_d   = acc_q;
    if ((phase_d == PH_SPACE) && !is_space(c)) begin
      phase_d = PH_SIGN;
    end
    if (phase_d == PH_SIGN) begin
      if (c == CH_MINUS) begin
        neg_d = ~neg_d;
      end else if (c != CH_PLUS) begin
        phase_d = PH_DIGIT;
      end
    end
    if (phase_d == PH_DIGIT) begin
      if (!hit_any) begin
        phase_d = PH_FROZEN;
      end else begin
        acc_d = acc_q * 32'(alpha_i.base_length) + 32'(digit);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SPACE;
      neg_q   <= 1'b0;
      acc_q   <= '0;
    end else if (step_en_i) begin
      if (item_i.last) begin
        phase_q <= PH_SPACE;
        neg_q   <= 1'b0;
        acc_q   <= '0;
      end else begin
        phase_q <= phase_d;
        neg_q   <= neg_d;
        acc_q   <= acc_d;
      end
    end
  end

  assign res_o.value        = !alpha_i.base_valid ? 32'sd0 :
                              neg_d ? $signed(~acc_d + 32'd1) : $signed(acc_d);
  assign res_o.base_invalid = !alpha_i.base_valid;

  `S2I_ASSERT_NEXT(a_last_clears, step_en_i && item_i.last,
    (phase_q == PH_SPACE) && !neg_q && (acc_q == 32'd0), "state not cleared after last")
  `S2I_ASSERT_NEXT(a_frozen_holds, step_en_i && !item_i.last && (phase_q == PH_FROZEN),
    (phase_q == PH_FROZEN) && $stable(acc_q), "frozen parse moved")
  `S2I_ASSERT_NEXT(a_idle_holds, !step_en_i,
    $stable(phase_q) && $stable(neg_q) && $stable(acc_q), "state changed without a beat")

endmodule

/* src/string_to_integer_any_base.sv */
// Top level of the string-to-integer parser with a configurable alphabet.
// Depends on s2i_pkg, s2i_cfg, s2i_parse and the assertion macro header.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one character
//   per beat with a last flag. Output channel (out_valid_o / out_stall_i /
//   out_data_o) carries one result per string: signed value and base_invalid.
//   A beat moves when valid is high and stall is low.
//   Configuration writes (cfg_valid_i / cfg_ready_o, index 0 alphabet_low,
//   1 alphabet_high, 2 base_length) are always ready; write them only while
//   no string is in flight.
//   Throughput: one character per cycle unless a held last character stalls
//   the input; match and multiply-add are combinational between the input
//   register and the result register. The result of a last character is
//   registered in the result register, which drives out_valid_o.
//   Stall: while a result waits under out_stall_i, characters without last
//   keep flowing; a held last character stalls the input until the result
//   slot frees.
//   Reset: clears the alphabet, the radix, the parse state and both valids.
module string_to_integer_any_base #(
  parameter int unsigned MAX_SYMBOLS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  s2i_pkg::in_t                 in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output s2i_pkg::out_t                out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [s2i_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [s2i_pkg::CfgDataW-1:0] cfg_data_i
);
  import s2i_pkg::*;
  `include "string_to_integer_any_base_defines.svh"

  in_t    in_q;
  logic   in_vld_q, in_vld_d;
  out_t   out_q;
  logic   out_vld_q, out_vld_d;
  out_t   res;
  alpha_t alpha;
  logic   advance;
  logic   in_take;

  s2i_cfg #(
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .alpha_o    (alpha)
  );

  s2i_parse #(
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_en_i(advance),
    .item_i   (in_q),
    .alpha_i  (alpha),
    .res_o    (res)
  );

  assign advance    = in_vld_q && (!in_q.last || !out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (advance && in_q.last) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (advance && in_q.last) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  `S2I_ASSERT_IMPL(a_invalid_zero, out_vld_q && out_q.base_invalid,
    out_q.value == 32'sd0, "invalid alphabet result with nonzero value")
  `S2I_ASSERT_NEXT(a_take_held, in_take, in_vld_q, "accepted beat not held")
  `S2I_ASSERT_NEXT(a_last_result, advance && in_q.last, out_vld_q,
    "last character gave no result")
  `S2I_ASSERT(a_stall_only_last, !in_stall_o || (in_vld_q && in_q.last && out_vld_q),
    "input stalled without a held last character")

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for string_to_integer_any_base: streams characters under many
// alphabet settings and predicts each parsed result. Depends on s2i_pkg and the RTL only.
module testbench;
  import s2i_pkg::*;

  localparam int NumPhases    = 12;
  localparam int CharsPerSet  = 63;
  localparam int CycleLimit   = 300000;
  localparam logic [63:0] HexLo = 64'h3736353433323130;
  localparam logic [63:0] HexHi = 64'h6665646362613938;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_t                 in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_t                out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  string_to_integer_any_base dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Parser state and register copies
  logic [63:0] alpha_lo = '0;
  logic [63:0] alpha_hi = '0;
  logic [4:0]  radix    = '0;
  phase_e      parse_ph = PH_SPACE;
  logic        neg_flag = 1'b0;
  logic [31:0] acc      = '0;

  in_t  pending_chars[$];
  out_t expected_results[$];
  out_t want;
  int   send_idle_pct = 0;
  int   stall_pct     = 0;
  int   fail_cnt      = 0;
  int   n_chars       = 0;
  int   n_results     = 0;
  int   n_strings     = 0;
  int   cycles        = 0;

  function automatic logic is_blank(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
           c == CH_FF || c == CH_CR;
  endfunction

  // 0..5 whitespace, 6 plus, 7 minus, 8 zero byte
  function automatic logic [7:0] odd_char(int k);
    case (k)
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      3: return CH_VT;
      4: return CH_FF;
      5: return CH_CR;
      6: return CH_PLUS;
      7: return CH_MINUS;
      default: return CH_NUL;
    endcase
  endfunction

  function automatic logic [7:0] symbol(int k);
    logic [127:0] all;
    all = {alpha_hi, alpha_lo};
    return all[k*8 +: 8];
  endfunction

  function automatic int digit_value(logic [7:0] c);
    int n;
    n = (radix > AlphaSym) ? AlphaSym : int'(radix);
    if (c == CH_NUL) return -1;
    for (int k = 0; k < n; k++)
      if (symbol(k) == c) return k;
    return -1;
  endfunction

  function automatic bit alphabet_ok();
    logic [7:0] s;
    if (radix < 2 || radix > AlphaSym) return 1'b0;
    for (int i = 0; i < int'(radix); i++) begin
      s = symbol(i);
      if (s == CH_NUL || s == CH_PLUS || s == CH_MINUS || is_blank(s)) return 1'b0;
      for (int j = i + 1; j < int'(radix); j++)
        if (symbol(j) == s) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic step_parser(in_t beat);
    int   d;
    out_t res;
    if (parse_ph == PH_SPACE && !is_blank(beat.char_code)) parse_ph = PH_SIGN;
    if (parse_ph == PH_SIGN) begin
      if (beat.char_code == CH_MINUS) neg_flag = !neg_flag;
      else if (beat.char_code != CH_PLUS) parse_ph = PH_DIGIT;
    end
    if (parse_ph == PH_DIGIT) begin
      d = digit_value(beat.char_code);
      if (d < 0) parse_ph = PH_FROZEN;
      else acc = acc * 32'(radix) + 32'(d);
    end
    if (beat.last) begin
      if (alphabet_ok()) begin
        res.value        = neg_flag ? 32'd0 - acc : acc;
        res.base_invalid = 1'b0;
      end else begin
        res.value        = '0;
        res.base_invalid = 1'b1;
      end
      expected_results.push_back(res);
      parse_ph = PH_SPACE;
      neg_flag = 1'b0;
      acc      = '0;
    end
  endtask

  task automatic push_char(logic [7:0] c, logic fin);
    in_t beat;
    beat.char_code = c;
    beat.last      = fin;
    pending_chars.push_back(beat);
    if (fin) n_strings++;
  endtask

  task automatic push_text(string s, logic fin);
    for (int i = 0; i < s.len(); i++)
      push_char(s[i], fin && i == s.len() - 1);
  endtask

  // Mostly well-formed strings with random content, some raw noise
  task automatic add_string(output int counted);
    logic [7:0] s[$];
    int         used;
    int         n_dig;
    used = (radix > AlphaSym) ? AlphaSym : int'(radix);
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 6)) s.push_back(8'($urandom()));
      counted = s.size();
    end else begin
      repeat ($urandom_range(0, 3)) s.push_back(odd_char($urandom_range(0, 5)));
      repeat ($urandom_range(0, 3)) s.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
      n_dig = ($urandom_range(4) == 0) ? $urandom_range(8, 14) : $urandom_range(0, 7);
      repeat (n_dig)
        s.push_back(used > 0 ? symbol($urandom_range(0, used - 1)) : 8'($urandom()));
      counted = s.size();
      if ($urandom_range(4) == 0)
        repeat ($urandom_range(1, 3)) s.push_back(8'($urandom()));
      if (s.size() == 0) s.push_back(8'($urandom()));
    end
    if (counted == 0) counted = 1;
    foreach (s[i]) push_char(s[i], i == s.size() - 1);
  endtask

  task automatic fill_alphabet(output logic [15:0][7:0] pick);
    logic [7:0] c;
    bit         dup;
    for (int i = 0; i < AlphaSym; i++) begin
      do begin
        c   = 8'($urandom_range(1, 255));
        dup = 1'b0;
        for (int j = 0; j < i; j++)
          if (pick[j] == c) dup = 1'b1;
      end while (dup || c == CH_PLUS || c == CH_MINUS || is_blank(c));
      pick[i] = c;
    end
  endtask

  // Leaves valid high; the caller drops it after the last write
  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_ALPHA_LO: alpha_lo = data;
      CFG_ALPHA_HI: alpha_hi = data;
      CFG_BASE_LEN: radix = data[LenW-1:0];
      default: ;
    endcase
  endtask

  // Character driver: hold while stalled, advance on acceptance
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        step_parser(in_data_i);
        n_chars++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data_i  <= pending_chars.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result beat: value %0d base_invalid %0b",
                 out_data_o.value, out_data_o.base_invalid);
          fail_cnt++;
        end else begin
          want = expected_results.pop_front();
          n_results++;
          if (out_data_o.value !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, out_data_o.value);
            fail_cnt++;
          end
          if (out_data_o.base_invalid !== want.base_invalid) begin
            $error("base_invalid: expected %0b, got %0b",
                   want.base_invalid, out_data_o.base_invalid);
            fail_cnt++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    logic [15:0][7:0] pick;
    logic [63:0]      lo;
    logic [63:0]      hi;
    logic [4:0]       len;
    int               n;
    int               i;
    int               budget;
    int               got;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int ph = 0; ph < NumPhases; ph++) begin
      @(posedge clk_i);
      fill_alphabet(pick);
      n = $urandom_range(2, 16);
      case (ph)
        2: pick[1:0] = 16'h3130;
        6: begin
          i = $urandom_range(0, n - 2);
          pick[$urandom_range(i + 1, n - 1)] = pick[i];
        end
        7: pick[$urandom_range(0, n - 1)] = odd_char($urandom_range(0, 8));
        default: ;
      endcase
      lo  = pick[7:0];
      hi  = pick[15:8];
      len = 5'(n);
      case (ph)
        0: begin
          lo  = '0;
          hi  = '0;
          len = '0;
        end
        1: begin
          lo  = HexLo;
          hi  = HexHi;
          len = 5'd16;
        end
        2: len = 5'd2;
        4: len = 5'd1;
        5: begin
          lo  = HexLo;
          hi  = HexHi;
          len = 5'd31;
        end
        8: begin
          lo  = '1;
          hi  = '1;
          len = 5'd16;
        end
        9: len = 5'd16;
        10: begin
          lo  = HexLo;
          hi  = HexHi;
          len = 5'd17;
        end
        default: ;
      endcase
      cfg_write(CFG_ALPHA_LO, lo);
      cfg_write(CFG_ALPHA_HI, hi);
      cfg_write(CFG_BASE_LEN, 64'(len));
      cfg_valid_i <= 1'b0;
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 81;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 81;
        end
        default: begin
          send_idle_pct = 10;
          stall_pct     = 10;
        end
      endcase
      if (ph == 1) begin
        for (int k = 0; k < 6; k++) push_char(odd_char(k), 1'b0);
        push_text("-+-a7", 1'b1);
        push_text("1", 1'b0);
        push_char(CH_NUL, 1'b0);
        push_char(8'hFF, 1'b1);
        push_text("3z4", 1'b1);
        push_text("-", 1'b1);
        push_text("fffffffff", 1'b1);
      end
      budget = 0;
      while (budget < CharsPerSet) begin
        add_string(got);
        budget += got;
      end
      while (pending_chars.size() != 0 || in_valid_i || n_results < n_strings)
        @(posedge clk_i);
      repeat (4) @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      fail_cnt++;
    end
    $display("tb: %0d characters sent, %0d results checked", n_chars, n_results);
    $display("tb: %0d alphabet settings, valid and invalid, under four idle patterns",
             NumPhases);
    if (fail_cnt == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/s2i_pkg.sv
src/s2i_cfg.sv
src/s2i_parse.sv
src/string_to_integer_any_base.sv
tb/testbench.sv
